@@ sv/fpsa_pkg.sv @@
// Shared types, codes and defaults for the free page stack allocator.
// No dependencies; fpsa_front, fpsa_queue, fpsa_back, the top level and the testbench use it by scoped names.
package fpsa_pkg;

  localparam int ADDR_W = 64;
  localparam int STAT_W = 3;
  localparam int MODE_W = 2;
  localparam int CFG_IDX_W = 1;

  localparam int DEF_PAGE_BYTES = 4096;
  localparam int DEF_MAX_PAGES  = 16384;

  // Request modes on the input channel
  localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FREE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FILL  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HEAP_START = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MEM_END    = 1'b1;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK         = 3'd0,
    ST_EMPTY      = 3'd1,
    ST_MISALIGNED = 3'd2,
    ST_BELOW_HEAP = 3'd3,
    ST_BEYOND_END = 3'd4,
    ST_FULL       = 3'd5
  } status_t;

  // Work for the back end after classification
  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_PUSH  = 2'd1,
    OP_FILL  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [ADDR_W-1:0] addr;
    status_t           st;
  } cmd_t;

  typedef struct packed {
    logic [ADDR_W-1:0] heap_start;
    logic [ADDR_W-1:0] mem_end;
  } cfg_t;

endpackage

@@ sv/fpsa_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fpsa_ram #(
  parameter int WIDTH = 52,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write and read ports
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ sv/fpsa_front.sv @@
// Front end: configuration registers and request classification.
// Depends on fpsa_pkg; feeds classified commands to the command queue.
module fpsa_front #(
  parameter int PAGE_BYTES = fpsa_pkg::DEF_PAGE_BYTES
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [fpsa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fpsa_pkg::ADDR_W-1:0]     cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [fpsa_pkg::MODE_W-1:0]     in_mode,
  input  logic [fpsa_pkg::ADDR_W-1:0]     in_page_address,
  output logic                            cmd_valid,
  input  logic                            cmd_ready,
  output fpsa_pkg::cmd_t                  cmd,
  output fpsa_pkg::cfg_t                  cfg
);

  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int AW = fpsa_pkg::ADDR_W;

  logic [AW-1:0] heap_r, heap_nxt;
  logic [AW-1:0] end_r, end_nxt;
  logic          misaligned;
  logic          below_heap;
  logic [AW:0]   page_end;
  logic          fits;

  // Take configuration writes
  always_comb begin
    heap_nxt = heap_r;
    end_nxt  = end_r;
    if (cfg_we) begin
      case (cfg_index)
        fpsa_pkg::REG_HEAP_START: heap_nxt = cfg_wdata;
        fpsa_pkg::REG_MEM_END:    end_nxt  = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_r <= '0;
      end_r  <= '0;
    end else begin
      heap_r <= heap_nxt;
      end_r  <= end_nxt;
    end
  end

  // Check a freed page: alignment, heap floor, end within memory
  assign misaligned = |in_page_address[PAGE_SHIFT-1:0];
  assign below_heap = in_page_address < heap_r;
  assign page_end   = {1'b0, in_page_address} + (AW+1)'(PAGE_BYTES);
  assign fits       = page_end <= {1'b0, end_r};

  // Classify the request
  always_comb begin
    cmd.addr = in_page_address;
    cmd.st   = fpsa_pkg::ST_OK;
    cmd.op   = fpsa_pkg::OP_NONE;
    case (in_mode)
      fpsa_pkg::MODE_ALLOC: cmd.op = fpsa_pkg::OP_ALLOC;
      fpsa_pkg::MODE_FREE: begin
        if (misaligned) begin
          cmd.st = fpsa_pkg::ST_MISALIGNED;
        end else if (below_heap) begin
          cmd.st = fpsa_pkg::ST_BELOW_HEAP;
        end else if (!fits) begin
          cmd.st = fpsa_pkg::ST_BEYOND_END;
        end else begin
          cmd.op = fpsa_pkg::OP_PUSH;
        end
      end
      fpsa_pkg::MODE_FILL: cmd.op = fpsa_pkg::OP_FILL;
      default: ;
    endcase
  end

  assign cmd_valid      = in_valid;
  assign in_ready       = cmd_ready;
  assign cfg.heap_start = heap_r;
  assign cfg.mem_end    = end_r;

endmodule

@@ sv/fpsa_queue.sv @@
// Two-entry command queue between the front and back ends.
// Depends on fpsa_pkg for the command type.
module fpsa_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  fpsa_pkg::cmd_t push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output fpsa_pkg::cmd_t pop_data
);

  fpsa_pkg::cmd_t entry_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     fill_r, fill_nxt;
  logic           do_push;
  logic           do_pop;

  assign push_ready = fill_r != 2'd2;
  assign pop_valid  = fill_r != 2'd0;
  assign pop_data   = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ do_push;
    rd_ptr_nxt = rd_ptr_r ^ do_pop;
    fill_nxt   = fill_r;
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + 2'd1;
    end else if (!do_push && do_pop) begin
      fill_nxt = fill_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // Store the pushed beat
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ sv/fpsa_back.sv @@
// Back end: page stack (count plus RAM), fill walker and result register.
// Depends on fpsa_pkg and fpsa_ram.
module fpsa_back #(
  parameter int PAGE_BYTES = fpsa_pkg::DEF_PAGE_BYTES,
  parameter int MAX_PAGES  = fpsa_pkg::DEF_MAX_PAGES
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  fpsa_pkg::cfg_t              cfg,
  input  logic                        cmd_valid,
  output logic                        cmd_ready,
  input  fpsa_pkg::cmd_t              cmd,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [fpsa_pkg::ADDR_W-1:0] out_granted_address,
  output logic [fpsa_pkg::STAT_W-1:0] out_status
);

  localparam int AW         = fpsa_pkg::ADDR_W;
  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int PN_W       = AW - PAGE_SHIFT;
  localparam int CNT_W      = $clog2(MAX_PAGES + 1);
  localparam int IDX_W      = $clog2(MAX_PAGES);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PAGES);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_FILL = 3'b100
  } state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [PN_W:0]      cur_r, cur_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [AW-1:0]      out_addr_r, out_addr_nxt;
  fpsa_pkg::status_t  out_st_r, out_st_nxt;

  logic               out_free;
  logic [CNT_W-1:0]   count_dec;
  logic [PN_W-1:0]    heap_pn;
  logic               heap_rem;
  logic [PN_W:0]      end_pn;
  logic [PN_W:0]      cur_inc;
  logic               fill_fits;
  logic               full;

  logic               ram_we;
  logic               ram_re;
  logic [PN_W-1:0]    ram_wdata;
  logic [PN_W-1:0]    ram_rdata;

  assign out_free  = !out_valid_r || out_ready;
  assign count_dec = count_r - CNT_W'(1);
  assign full      = count_r == CNT_MAX;
  assign heap_pn   = cfg.heap_start[AW-1:PAGE_SHIFT];
  assign heap_rem  = |cfg.heap_start[PAGE_SHIFT-1:0];
  assign end_pn    = {1'b0, cfg.mem_end[AW-1:PAGE_SHIFT]};
  assign cur_inc   = cur_r + (PN_W+1)'(1);
  assign fill_fits = cur_inc <= end_pn;
  assign cmd_ready = (state_r == S_IDLE) && out_free;

  // Dispatch commands, walk fills, load results
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    cur_nxt       = cur_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_addr_nxt  = out_addr_r;
    out_st_nxt    = out_st_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_wdata     = cmd.addr[AW-1:PAGE_SHIFT];
    case (state_r)
      S_IDLE: begin
        if (cmd_valid && out_free) begin
          case (cmd.op)
            fpsa_pkg::OP_ALLOC: begin
              if (count_r == '0) begin
                out_valid_nxt = 1'b1;
                out_addr_nxt  = '0;
                out_st_nxt    = fpsa_pkg::ST_EMPTY;
              end else begin
                ram_re    = 1'b1;
                count_nxt = count_dec;
                state_nxt = S_READ;
              end
            end
            fpsa_pkg::OP_PUSH: begin
              out_valid_nxt = 1'b1;
              out_addr_nxt  = '0;
              if (full) begin
                out_st_nxt = fpsa_pkg::ST_FULL;
              end else begin
                ram_we     = 1'b1;
                count_nxt  = count_r + CNT_W'(1);
                out_st_nxt = fpsa_pkg::ST_OK;
              end
            end
            fpsa_pkg::OP_FILL: begin
              // Rounding past the top of the address space pushes nothing
              if (heap_rem && (&heap_pn)) begin
                out_valid_nxt = 1'b1;
                out_addr_nxt  = '0;
                out_st_nxt    = fpsa_pkg::ST_OK;
              end else begin
                cur_nxt   = {1'b0, heap_pn} + (PN_W+1)'(heap_rem);
                state_nxt = S_FILL;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
              out_addr_nxt  = '0;
              out_st_nxt    = cmd.st;
            end
          endcase
        end
      end
      S_READ: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_addr_nxt  = {ram_rdata, {PAGE_SHIFT{1'b0}}};
          out_st_nxt    = fpsa_pkg::ST_OK;
          state_nxt     = S_IDLE;
        end
      end
      S_FILL: begin
        ram_wdata = cur_r[PN_W-1:0];
        if (fill_fits && !full) begin
          ram_we    = 1'b1;
          count_nxt = count_r + CNT_W'(1);
          cur_nxt   = cur_inc;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_addr_nxt  = '0;
          out_st_nxt    = fill_fits ? fpsa_pkg::ST_FULL : fpsa_pkg::ST_OK;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers hold without reset
  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    out_addr_r <= out_addr_nxt;
    out_st_r   <= out_st_nxt;
  end

  fpsa_ram #(
    .WIDTH (PN_W),
    .DEPTH (MAX_PAGES)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[IDX_W-1:0]),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (count_dec[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  assign out_valid           = out_valid_r;
  assign out_granted_address = out_addr_r;
  assign out_status          = out_st_r;

  // The stack never holds more than its depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_MAX)
    else $error("page count above stack depth");

  // One RAM access per cycle
  a_one_port: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("stack read and write in the same cycle");

  // Entering the read wait follows a pop of exactly one page
  a_pop_one: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ && $past(state_r) == S_IDLE && $past(rst_n))
      |-> count_r == $past(count_r) - CNT_W'(1))
    else $error("alloc did not pop one page");

  // Each fill push adds one page
  a_fill_push: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FILL && ram_we) |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("fill push did not grow the stack");

endmodule

@@ sv/free_page_stack_allocator.sv @@
// Top level of the free page stack allocator: front end, command queue, back end.
// Depends on fpsa_pkg, fpsa_front, fpsa_queue, fpsa_back and fpsa_ram.
//
//   Channel  Direction  Handshake          Payload
//   in_      input      in_valid/in_ready  in_mode, in_page_address
//   out_     output     out_valid/out_ready out_granted_address, out_status
//   cfg_     input      cfg_we             cfg_index, cfg_wdata
//
// A request is classified in the cycle it is accepted and queued (two entries).
// In the back end, free and error results load the output register from idle; alloc
// waits in a read state for the registered stack RAM read; fill pushes one page per cycle.
// Reset clears the page count and both registers; the stack RAM is not cleared.
// A stalled output holds the back end; the queue keeps accepting until full.
module free_page_stack_allocator #(
  parameter int PAGE_BYTES = fpsa_pkg::DEF_PAGE_BYTES,
  parameter int MAX_PAGES  = fpsa_pkg::DEF_MAX_PAGES
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [fpsa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fpsa_pkg::ADDR_W-1:0]    cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [fpsa_pkg::MODE_W-1:0]    in_mode,
  input  logic [fpsa_pkg::ADDR_W-1:0]    in_page_address,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [fpsa_pkg::ADDR_W-1:0]    out_granted_address,
  output logic [fpsa_pkg::STAT_W-1:0]    out_status
);

  fpsa_pkg::cmd_t front_cmd;
  fpsa_pkg::cmd_t back_cmd;
  fpsa_pkg::cfg_t cfg;
  logic           front_valid;
  logic           front_ready;
  logic           back_valid;
  logic           back_ready;

  fpsa_front #(
    .PAGE_BYTES (PAGE_BYTES)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_mode         (in_mode),
    .in_page_address (in_page_address),
    .cmd_valid       (front_valid),
    .cmd_ready       (front_ready),
    .cmd             (front_cmd),
    .cfg             (cfg)
  );

  fpsa_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_data  (front_cmd),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready),
    .pop_data   (back_cmd)
  );

  fpsa_back #(
    .PAGE_BYTES (PAGE_BYTES),
    .MAX_PAGES  (MAX_PAGES)
  ) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg                 (cfg),
    .cmd_valid           (back_valid),
    .cmd_ready           (back_ready),
    .cmd                 (back_cmd),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_granted_address (out_granted_address),
    .out_status          (out_status)
  );

endmodule

@@ tb/free_page_stack_allocator_tb.sv @@
// Self-checking testbench for free_page_stack_allocator: predicts each grant and
// status from a local copy of the page pool and compares every result beat in order.
// Depends on fpsa_pkg and the free_page_stack_allocator RTL.
`timescale 1ns / 100ps

module free_page_stack_allocator_tb;

  localparam int ADDR_W     = fpsa_pkg::ADDR_W;
  localparam int MODE_W     = fpsa_pkg::MODE_W;
  localparam int STAT_W     = fpsa_pkg::STAT_W;
  localparam int CFG_IDX_W  = fpsa_pkg::CFG_IDX_W;
  localparam int PAGE_BYTES = fpsa_pkg::DEF_PAGE_BYTES;
  localparam int POOL_PAGES = fpsa_pkg::DEF_MAX_PAGES;
  localparam logic [ADDR_W-1:0] PAGE_SZ  = ADDR_W'(PAGE_BYTES);
  localparam logic [ADDR_W-1:0] ALL_ONES = '1;
  localparam logic [MODE_W-1:0] MODE_IGNORED = 2'd3;
  localparam int RAND_ITEMS = 1720;
  localparam int MAX_SHOWN  = 40;

  typedef struct {
    logic [MODE_W-1:0] mode;
    logic [ADDR_W-1:0] addr;
  } req_t;

  typedef struct {
    logic [ADDR_W-1:0] addr;
    fpsa_pkg::status_t st;
  } grant_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [ADDR_W-1:0]    cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [MODE_W-1:0]    in_mode = '0;
  logic [ADDR_W-1:0]    in_page_address = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [ADDR_W-1:0]    out_granted_address;
  logic [STAT_W-1:0]    out_status;

  free_page_stack_allocator #(
    .PAGE_BYTES(PAGE_BYTES),
    .MAX_PAGES (POOL_PAGES)
  ) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_mode            (in_mode),
    .in_page_address    (in_page_address),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_granted_address(out_granted_address),
    .out_status         (out_status)
  );

  always #1 clk = ~clk;

  // Local copy of the pool and the region registers
  logic [ADDR_W-1:0] pool_pages [POOL_PAGES];
  int                pool_depth = 0;
  logic [ADDR_W-1:0] heap_lo_m = '0;
  logic [ADDR_W-1:0] mem_top_m = '0;

  req_t   request_q [$];
  grant_t grant_q [$];
  int     issued = 0;
  int     in_beats = 0;
  int     errors = 0;

  function automatic bit fits_region(logic [ADDR_W-1:0] base);
    if (base > mem_top_m) return 1'b0;
    return (mem_top_m - base) >= PAGE_SZ;
  endfunction

  function automatic bit pool_push(logic [ADDR_W-1:0] base);
    if (pool_depth >= POOL_PAGES) return 1'b0;
    pool_pages[pool_depth] = base;
    pool_depth++;
    return 1'b1;
  endfunction

  // Checks run in priority order; a failed check leaves the pool alone
  function automatic fpsa_pkg::status_t release_page(logic [ADDR_W-1:0] addr);
    if (addr % PAGE_SZ != 0) return fpsa_pkg::ST_MISALIGNED;
    if (addr < heap_lo_m) return fpsa_pkg::ST_BELOW_HEAP;
    if (!fits_region(addr)) return fpsa_pkg::ST_BEYOND_END;
    if (!pool_push(addr)) return fpsa_pkg::ST_FULL;
    return fpsa_pkg::ST_OK;
  endfunction

  // Push every whole page from the rounded-up heap start, ascending
  function automatic fpsa_pkg::status_t fill_pool();
    logic [ADDR_W-1:0] rem;
    logic [ADDR_W-1:0] cur;
    rem = heap_lo_m % PAGE_SZ;
    cur = heap_lo_m;
    if (rem != 0) begin
      if (cur > ALL_ONES - (PAGE_SZ - rem)) return fpsa_pkg::ST_OK;
      cur = cur + (PAGE_SZ - rem);
    end
    while (fits_region(cur)) begin
      if (!pool_push(cur)) return fpsa_pkg::ST_FULL;
      cur = cur + PAGE_SZ;
    end
    return fpsa_pkg::ST_OK;
  endfunction

  function automatic grant_t predict_grant(logic [MODE_W-1:0] mode, logic [ADDR_W-1:0] addr);
    grant_t g;
    g.addr = '0;
    g.st   = fpsa_pkg::ST_OK;
    case (mode)
      fpsa_pkg::MODE_ALLOC: begin
        if (pool_depth == 0) begin
          g.st = fpsa_pkg::ST_EMPTY;
        end else begin
          pool_depth--;
          g.addr = pool_pages[pool_depth];
        end
      end
      fpsa_pkg::MODE_FREE: g.st = release_page(addr);
      fpsa_pkg::MODE_FILL: g.st = fill_pool();
      default: ;
    endcase
    return g;
  endfunction

  task automatic report_mismatch(string what, logic [ADDR_W-1:0] got,
                                 logic [ADDR_W-1:0] want);
    errors++;
    if (errors <= MAX_SHOWN)
      $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
  endtask

  // Predict on each accepted request, then check each result beat
  always @(posedge clk) begin : monitor
    grant_t g;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        in_beats++;
        g = predict_grant(in_mode, in_page_address);
        grant_q.push_back(g);
      end
      if (out_valid && out_ready) begin
        if (grant_q.size() == 0) begin
          report_mismatch("result with nothing pending", out_granted_address, '0);
        end else begin
          g = grant_q.pop_front();
          if (out_granted_address !== g.addr)
            report_mismatch("granted_address", out_granted_address, g.addr);
          if (out_status !== g.st)
            report_mismatch("status", ADDR_W'(out_status), ADDR_W'(g.st));
        end
      end
    end
  end

  // Request driver: bursts of random length with random gaps
  req_t drv_req;
  int   burst_left = 0;
  int   gap_left = 0;

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_beats == issued) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (request_q.size() == 0) begin
        in_valid <= 1'b0;
      end else begin
        drv_req = request_q.pop_front();
        in_mode         <= drv_req.mode;
        in_page_address <= drv_req.addr;
        in_valid        <= 1'b1;
        issued++;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 30);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
  end

  // Result receiver: ready runs broken by stalls of its own
  int run_left = 0;
  int stall_left = 0;

  always @(negedge clk) begin
    if (run_left == 0 && stall_left == 0) begin
      run_left   = $urandom_range(1, 40);
      stall_left = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 12) : 0;
    end
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
      run_left--;
    end
  end

  task automatic queue_req(logic [MODE_W-1:0] mode, logic [ADDR_W-1:0] addr);
    req_t r;
    r.mode = mode;
    r.addr = addr;
    request_q.push_back(r);
  endtask

  // Hold until every request is taken and every result is back
  task automatic drain();
    while (request_q.size() != 0 || in_beats != issued || grant_q.size() != 0)
      @(negedge clk);
  endtask

  // Rewrite both region registers with the block idle
  task automatic set_region(logic [ADDR_W-1:0] heap_lo, logic [ADDR_W-1:0] mem_top);
    drain();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= fpsa_pkg::REG_HEAP_START;
    cfg_wdata <= heap_lo;
    heap_lo_m = heap_lo;
    @(negedge clk);
    cfg_index <= fpsa_pkg::REG_MEM_END;
    cfg_wdata <= mem_top;
    mem_top_m = mem_top;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    logic [ADDR_W-1:0] h;
    logic [ADDR_W-1:0] e;
    logic [ADDR_W-1:0] a;
    logic [ADDR_W-1:0] span;
    logic [ADDR_W-1:0] addr;
    logic [MODE_W-1:0] mode;
    int kind;
    int n_items;
    int alloc_w;
    int pick;
    int done_items;
    int pause_at;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Empty region: empty pool, ignored mode, nothing to fill, nothing fits
    set_region('0, '0);
    queue_req(fpsa_pkg::MODE_ALLOC, '0);
    queue_req(MODE_IGNORED, ALL_ONES);
    queue_req(fpsa_pkg::MODE_FILL, '0);
    queue_req(fpsa_pkg::MODE_FREE, '0);

    // Unaligned heap start rounds up; three whole pages fit
    set_region(64'h8000_0800, 64'h8000_4010);
    queue_req(fpsa_pkg::MODE_FILL, '0);
    queue_req(fpsa_pkg::MODE_ALLOC, '0);
    queue_req(fpsa_pkg::MODE_FREE, 64'h8000_0800);
    queue_req(fpsa_pkg::MODE_FREE, 64'h8000_0000);
    queue_req(fpsa_pkg::MODE_FREE, 64'h8000_4000);
    queue_req(fpsa_pkg::MODE_FREE, 64'hFFFF_FFFF_FFFF_F000);
    queue_req(fpsa_pkg::MODE_FREE, 64'h8000_1000);
    queue_req(fpsa_pkg::MODE_ALLOC, '0);
    queue_req(fpsa_pkg::MODE_ALLOC, '0);
    queue_req(fpsa_pkg::MODE_FREE, ALL_ONES);

    // Heap start whose round-up passes the top of the address space
    set_region(64'hFFFF_FFFF_FFFF_F001, ALL_ONES);
    queue_req(fpsa_pkg::MODE_FILL, '0);
    queue_req(fpsa_pkg::MODE_FREE, 64'hFFFF_FFFF_FFFF_F000);
    set_region(ALL_ONES, ALL_ONES);
    queue_req(fpsa_pkg::MODE_FILL, '0);

    // Topmost whole page; older pages come back without a recheck
    set_region(64'hFFFF_FFFF_FFFF_E000, ALL_ONES);
    queue_req(fpsa_pkg::MODE_FILL, '0);
    queue_req(fpsa_pkg::MODE_FREE, 64'hFFFF_FFFF_FFFF_E000);
    queue_req(fpsa_pkg::MODE_ALLOC, '0);
    queue_req(fpsa_pkg::MODE_ALLOC, '0);
    queue_req(fpsa_pkg::MODE_ALLOC, '0);
    queue_req(fpsa_pkg::MODE_ALLOC, '0);
    queue_req(fpsa_pkg::MODE_ALLOC, '0);

    // Random phases, each with a small region of its own
    done_items = 0;
    while (done_items < RAND_ITEMS) begin
      kind = $urandom_range(0, 9);
      if (kind == 0) h = {$urandom, $urandom};
      else if (kind == 1) h = ALL_ONES - ADDR_W'($urandom_range(0, 5 * PAGE_BYTES));
      else h = {32'($urandom_range(0, 15)), $urandom};
      if ($urandom_range(0, 1) == 1) h[11:0] = '0;
      span = ADDR_W'($urandom_range(0, 24)) * PAGE_SZ;
      if ($urandom_range(0, 1) == 1) span = span + ADDR_W'($urandom_range(0, 4095));
      if (kind == 2) e = h - ADDR_W'($urandom_range(0, 2 * PAGE_BYTES));
      else e = (h > ALL_ONES - span) ? ALL_ONES : h + span;
      a = (h[11:0] == 0 || h > ALL_ONES - PAGE_SZ) ? h : {h[63:12] + 52'd1, 12'h0};
      set_region(h, e);

      case ($urandom_range(0, 2))
        0: alloc_w = 15;
        1: alloc_w = 45;
        default: alloc_w = 80;
      endcase
      n_items  = $urandom_range(60, 160);
      if (n_items > RAND_ITEMS - done_items) n_items = RAND_ITEMS - done_items;
      pause_at = ($urandom_range(0, 2) == 0) ? n_items / 2 : -1;

      for (int i = 0; i < n_items; i++) begin
        // Stop feeding until the block has answered everything
        if (i == pause_at) drain();
        pick = $urandom_range(0, 99);
        addr = {$urandom, $urandom};
        if (pick < alloc_w) begin
          mode = fpsa_pkg::MODE_ALLOC;
        end else if (pick < alloc_w + 4) begin
          mode = fpsa_pkg::MODE_FILL;
        end else if (pick < alloc_w + 7) begin
          mode = MODE_IGNORED;
        end else begin
          mode = fpsa_pkg::MODE_FREE;
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: addr = a + ADDR_W'($urandom_range(0, 24)) * PAGE_SZ;
            5: addr = a - ADDR_W'($urandom_range(1, 3)) * PAGE_SZ;
            6: addr = {e[63:12], 12'h0} + ADDR_W'($urandom_range(0, 2)) * PAGE_SZ;
            7: addr = a + ADDR_W'($urandom_range(1, PAGE_BYTES - 1));
            8: ;
            default: addr = a + ADDR_W'($urandom_range(0, 27)) * PAGE_SZ;
          endcase
        end
        queue_req(mode, addr);
      end
      done_items += n_items;
    end

    // Whole address space: fill until the pool is full, then push against it
    set_region('0, ALL_ONES);
    queue_req(fpsa_pkg::MODE_FILL, '0);
    queue_req(fpsa_pkg::MODE_FILL, '0);
    queue_req(fpsa_pkg::MODE_ALLOC, '0);
    queue_req(fpsa_pkg::MODE_FREE, 64'h2000);
    queue_req(fpsa_pkg::MODE_FREE, 64'h3000);
    queue_req(fpsa_pkg::MODE_ALLOC, '0);

    drain();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog for a hung handshake
  initial begin
    #1000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
